// ===== hdl/ppi_pkg.sv =====
package ppi_pkg;

	typedef enum logic [1:0] {
		KIND_CPU_WR = 2'd0,
		KIND_CPU_RD = 2'd1,
		KIND_PIN_WR = 2'd2,
		KIND_PIN_RD = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PORT_A    = 2'd0,
		PORT_B    = 2'd1,
		PORT_C    = 2'd2,
		PORT_CTRL = 2'd3
	} port_t;

	localparam int unsigned DIR_CLO_IN_BIT = 0;
	localparam int unsigned DIR_B_IN_BIT   = 1;
	localparam int unsigned DIR_CHI_IN_BIT = 3;
	localparam int unsigned DIR_A_IN_BIT   = 4;
	localparam int unsigned CTL_LOAD_BIT   = 7;
	localparam int unsigned CTL_VAL_BIT    = 0;

	typedef struct packed {
		kind_t      kind;
		port_t      port_sel;
		logic [7:0] data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] input_mask;
	} rsp_t;

	function automatic logic [7:0] port_in_bits(input logic [7:0] dir, input port_t p);
		logic [7:0] m;
		m = 8'h00;
		unique case (p)
			PORT_A: m = {8{dir[DIR_A_IN_BIT]}};
			PORT_B: m = {8{dir[DIR_B_IN_BIT]}};
			PORT_C: m = {{4{dir[DIR_CHI_IN_BIT]}}, {4{dir[DIR_CLO_IN_BIT]}}};
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/ppi_req_if.sv =====
interface ppi_req_if;
	import ppi_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [1:0] port_sel;
	logic [7:0] data;

	modport source (output valid, kind, port_sel, data, input ready);
	modport sink   (input valid, kind, port_sel, data, output ready);
endinterface

// ===== hdl/ppi_rsp_if.sv =====
interface ppi_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [7:0] input_mask;

	modport source (output valid, read_data, input_mask, input ready);
	modport sink   (input valid, read_data, input_mask, output ready);
endinterface

// ===== hdl/ppi_core.sv =====
module ppi_core
	import ppi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic commit,
	input  req_t item,
	output rsp_t result
);

	logic [7:0] out_a_q, out_b_q, out_c_q;
	logic [7:0] in_a_q, in_b_q, in_c_q;
	logic [7:0] dir_q;

	logic [7:0] out_sel, in_sel, mask, new_in, bit_mask;
	logic       is_port;

	assign is_port = (item.port_sel != PORT_CTRL);

	always_comb begin
		out_sel = 8'h00;
		in_sel  = 8'h00;
		unique case (item.port_sel)
			PORT_A: begin
				out_sel = out_a_q;
				in_sel  = in_a_q;
			end
			PORT_B: begin
				out_sel = out_b_q;
				in_sel  = in_b_q;
			end
			PORT_C: begin
				out_sel = out_c_q;
				in_sel  = in_c_q;
			end
			default: begin
				out_sel = 8'h00;
				in_sel  = 8'h00;
			end
		endcase
	end

	assign mask     = port_in_bits(dir_q, item.port_sel);
	assign new_in   = (in_sel & ~mask) | (item.data & mask);
	assign bit_mask = 8'h01 << item.data[3:1];

	always_comb begin
		result = '0;
		case (item.kind)
			KIND_CPU_RD: begin
				if (is_port) begin
					result.read_data = in_sel;
				end
			end
			KIND_PIN_RD: begin
				if (is_port) begin
					result.input_mask = mask;
					result.read_data  = (in_sel & mask) | (out_sel & ~mask);
				end
			end
			default: result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_a_q <= '0;
			out_b_q <= '0;
			out_c_q <= '0;
			in_a_q  <= '0;
			in_b_q  <= '0;
			in_c_q  <= '0;
			dir_q   <= '0;
		end else if (commit) begin
			case (item.kind)
				KIND_CPU_WR: begin
					unique case (item.port_sel)
						PORT_A: out_a_q <= item.data;
						PORT_B: out_b_q <= item.data;
						PORT_C: out_c_q <= item.data;
						default: begin
							if (item.data[CTL_LOAD_BIT]) begin
								dir_q <= item.data;
							end else if (item.data[CTL_VAL_BIT]) begin
								out_c_q <= out_c_q | bit_mask;
							end else begin
								out_c_q <= out_c_q & ~bit_mask;
							end
						end
					endcase
				end
				KIND_PIN_WR: begin
					unique case (item.port_sel)
						PORT_A: in_a_q <= new_in;
						PORT_B: in_b_q <= new_in;
						PORT_C: in_c_q <= new_in;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	a_dir_load: assert property (@(posedge clk) disable iff (!arst_n)
		commit && item.kind == KIND_CPU_WR && item.port_sel == PORT_CTRL
			&& item.data[CTL_LOAD_BIT] |=> dir_q == $past(item.data))
		else $error("Direction byte not loaded by a control write.");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(dir_q) && $stable(out_c_q) && $stable(in_c_q))
		else $error("State changed without an item being processed.");

	a_mask_only_pin_read: assert property (@(posedge clk) disable iff (!arst_n)
		result.input_mask != 8'h00 |-> item.kind == KIND_PIN_RD)
		else $error("Input mask set for an item that is not a pin-side read.");

endmodule

// ===== hdl/parallel_port_8255_mode0.sv =====
// An accepted item is held in the input register, where the core works on it;
// its result is then written into the result register and offered on the output.
// Throughput: one item per cycle unless the output stalls; the input and result
// registers let a new item enter while an earlier result still waits to be taken.
// Reset is asynchronous and active low: it clears all port latches, the
// direction byte (every port an output) and both pipeline valid flags.
module parallel_port_8255_mode0
	import ppi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ppi_req_if.sink   req,
	ppi_rsp_if.source rsp
);

	logic s1_valid_q;
	req_t item_s1;
	logic s2_valid_q;
	rsp_t result_s2;
	rsp_t core_result;
	logic adv;

	assign adv       = s1_valid_q && (!s2_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.kind     <= kind_t'(req.kind);
			item_s1.port_sel <= port_t'(req.port_sel);
			item_s1.data     <= req.data;
		end
	end

	ppi_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (adv),
		.item   (item_s1),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (adv) begin
			s2_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= core_result;
		end
	end

	assign rsp.valid      = s2_valid_q;
	assign rsp.read_data  = result_s2.read_data;
	assign rsp.input_mask = result_s2.input_mask;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> s1_valid_q)
		else $error("Accepted item did not reach the input register.");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !adv |=> s1_valid_q && $stable(item_s1))
		else $error("Stalled item lost or changed in the input register.");

	a_empty_out_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s2_valid_q |-> adv)
		else $error("Item held although the result register is empty.");

endmodule
